// ----- hdl/sha256_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// SHA-256 package
// Shared types, constants and round functions for the byte stream hasher.
// ---------------------------------------------------------------------------
package sha256_pkg;

   localparam int unsigned BlockBytes = 64;
   localparam int unsigned QueueDepth = 4;

   // block job handed from the front end to the compression engine
   typedef struct packed {
      logic [511:0] block;
      logic         final_block;
   } job_type;

   typedef logic [31:0] word_type;

   localparam logic [255:0] InitHash = {
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

   localparam logic [7:0] PadByte = 8'h80;
   localparam int unsigned LengthOffset = 56;

   localparam logic [31:0] RoundConsts [64] = '{
      32'h428a2f98,32'h71374491,32'hb5c0fbcf,32'he9b5dba5,32'h3956c25b,32'h59f111f1,
      32'h923f82a4,32'hab1c5ed5,32'hd807aa98,32'h12835b01,32'h243185be,32'h550c7dc3,
      32'h72be5d74,32'h80deb1fe,32'h9bdc06a7,32'hc19bf174,32'he49b69c1,32'hefbe4786,
      32'h0fc19dc6,32'h240ca1cc,32'h2de92c6f,32'h4a7484aa,32'h5cb0a9dc,32'h76f988da,
      32'h983e5152,32'ha831c66d,32'hb00327c8,32'hbf597fc7,32'hc6e00bf3,32'hd5a79147,
      32'h06ca6351,32'h14292967,32'h27b70a85,32'h2e1b2138,32'h4d2c6dfc,32'h53380d13,
      32'h650a7354,32'h766a0abb,32'h81c2c92e,32'h92722c85,32'ha2bfe8a1,32'ha81a664b,
      32'hc24b8b70,32'hc76c51a3,32'hd192e819,32'hd6990624,32'hf40e3585,32'h106aa070,
      32'h19a4c116,32'h1e376c08,32'h2748774c,32'h34b0bcb5,32'h391c0cb3,32'h4ed8aa4a,
      32'h5b9cca4f,32'h682e6ff3,32'h748f82ee,32'h78a5636f,32'h84c87814,32'h8cc70208,
      32'h90befffa,32'ha4506ceb,32'hbef9a3f7,32'hc67178f2};

   function automatic word_type rotr(input word_type x, input int unsigned n);
      rotr = (x >> n) | (x << (32 - n));
   endfunction

endpackage
`default_nettype wire

// ----- hdl/sha256_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Stream interfaces
// Valid/ready channels for message bytes and digest parts.
// ---------------------------------------------------------------------------
interface sha256_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       byte_present;
   logic       end_of_message;
   modport source (output valid, data_byte, byte_present, end_of_message, input ready);
   modport sink (input valid, data_byte, byte_present, end_of_message, output ready);
endinterface

interface sha256_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] digest_part;
   logic [1:0]  part_index;
   logic        last_part;
   modport source (output valid, digest_part, part_index, last_part, input ready);
   modport sink (input valid, digest_part, part_index, last_part, output ready);
endinterface
`default_nettype wire

// ----- hdl/sha256_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// SHA-256 front end
// Gathers bytes into blocks, applies padding and length, emits block jobs.
// ---------------------------------------------------------------------------
module sha256_front (
   input  wire logic               clock,
   input  wire logic               reset,
   sha256_req_if.sink              req,
   output sha256_pkg::job_type     job,
   output logic                    job_valid,
   input  wire logic               job_ready
);

   localparam logic [1:0] StIdle = 2'd0;
   localparam logic [1:0] StPad2 = 2'd1;
   localparam logic [1:0] StPad1 = 2'd2;

   logic [511:0] buf_ff, buf_in;
   logic [5:0]   cnt_ff, cnt_in;
   logic [63:0]  bits_ff, bits_in;
   logic [1:0]   state_ff, state_in;
   logic         take;

   // trailing padding blocks: zeros plus length, or pad byte, zeros and length
   logic [511:0] len_block, pad_block;
   assign len_block = {448'd0, bits_ff};
   assign pad_block = {sha256_pkg::PadByte, 440'd0, bits_ff};

   assign req.ready = (state_ff == StIdle) && job_ready;
   assign take = req.valid && req.ready;

   always_comb begin
      logic [511:0] b;
      logic [6:0]   n;
      logic [63:0]  nb;
      b = buf_ff;
      n = {1'b0, cnt_ff};
      nb = bits_ff;
      buf_in = buf_ff;
      cnt_in = cnt_ff;
      bits_in = bits_ff;
      state_in = state_ff;
      job_valid = 1'b0;
      job = '0;
      case (state_ff)
         StIdle: if (take) begin
            if (req.byte_present) begin
               b[511 - 8*n[5:0] -: 8] = req.data_byte;
               n = n + 7'd1;
               nb = bits_ff + 64'd8;
            end
            if (n == 7'd64) begin
               // full block goes out; an ending word needs one more pad block
               job_valid = 1'b1;
               job.block = b;
               job.final_block = 1'b0;
               n = 7'd0;
               if (req.end_of_message) state_in = StPad1;
            end else if (req.end_of_message) begin
               b[511 - 8*n[5:0] -: 8] = sha256_pkg::PadByte;
               for (int i = 0; i < 64; i++)
                  if (i > n) b[511 - 8*i -: 8] = 8'h00;
               if (n < 7'(sha256_pkg::LengthOffset)) begin
                  b[63:0] = nb;
                  job_valid = 1'b1;
                  job.block = b;
                  job.final_block = 1'b1;
                  nb = '0;
               end else begin
                  job_valid = 1'b1;
                  job.block = b;
                  job.final_block = 1'b0;
                  state_in = StPad2;
               end
               n = 7'd0;
            end
            buf_in = b;
            cnt_in = n[5:0];
            bits_in = nb;
         end
         StPad2: begin
            job_valid = 1'b1;
            job.block = len_block;
            job.final_block = 1'b1;
            if (job_ready) begin
               bits_in = '0;
               state_in = StIdle;
            end
         end
         StPad1: begin
            job_valid = 1'b1;
            job.block = pad_block;
            job.final_block = 1'b1;
            if (job_ready) begin
               bits_in = '0;
               state_in = StIdle;
            end
         end
         default: state_in = StIdle;
      endcase
   end

   always_ff @(posedge clock) begin
      buf_ff <= buf_in;
      if (reset) begin
         cnt_ff <= '0;
         bits_ff <= '0;
         state_ff <= StIdle;
      end else begin
         cnt_ff <= cnt_in;
         bits_ff <= bits_in;
         state_ff <= state_in;
      end
   end

endmodule
`default_nettype wire

// ----- hdl/sha256_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// SHA-256 job queue
// Short FIFO of block jobs between front end and compression engine.
// ---------------------------------------------------------------------------
module sha256_queue #(
   parameter int unsigned Depth = sha256_pkg::QueueDepth
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire sha256_pkg::job_type wr_job,
   input  wire logic               wr_valid,
   output logic                    wr_ready,
   output sha256_pkg::job_type     rd_job,
   output logic                    rd_valid,
   input  wire logic               rd_ready
);

   localparam int unsigned Aw = (Depth > 1) ? $clog2(Depth) : 1;

   sha256_pkg::job_type mem [Depth];
   logic [Aw-1:0] wp_ff, rp_ff;
   logic [Aw:0]   cnt_ff;
   logic          push, pop;

   assign wr_ready = cnt_ff != (Aw+1)'(Depth);
   assign rd_valid = cnt_ff != '0;
   assign push = wr_valid && wr_ready;
   assign pop = rd_valid && rd_ready;
   assign rd_job = mem[rp_ff];

   // storage
   always_ff @(posedge clock) begin
      if (push) mem[wp_ff] <= wr_job;
   end

   // pointers
   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0;
         rp_ff <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) wp_ff <= (wp_ff == Aw'(Depth - 1)) ? '0 : wp_ff + 1'b1;
         if (pop) rp_ff <= (rp_ff == Aw'(Depth - 1)) ? '0 : rp_ff + 1'b1;
         cnt_ff <= cnt_ff + (Aw+1)'(push) - (Aw+1)'(pop);
      end
   end

endmodule
`default_nettype wire

// ----- hdl/sha256_engine.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// SHA-256 compression engine
// One round per cycle, rolling 16-word schedule, digest output register.
// ---------------------------------------------------------------------------
module sha256_engine (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire sha256_pkg::job_type job,
   input  wire logic                job_valid,
   output logic                     job_ready,
   sha256_rsp_if.source             rsp
);

   localparam logic [1:0] StIdle = 2'd0;
   localparam logic [1:0] StRound = 2'd1;
   localparam logic [1:0] StAdd = 2'd2;
   localparam logic [1:0] StOut = 2'd3;

   logic [1:0]   state_ff;
   logic [5:0]   rnd_ff;
   logic [511:0] w_ff;
   logic [255:0] h_ff, v_ff;
   logic         fin_ff;
   logic [1:0]   part_ff;

   sha256_pkg::word_type a, b, c, d, e, f, g, hh, t1, t2, w0, wn, s0, s1;

   assign job_ready = state_ff == StIdle;
   assign {a, b, c, d, e, f, g, hh} = v_ff;
   assign w0 = w_ff[511:480];

   // round datapath
   always_comb begin
      t1 = hh + (sha256_pkg::rotr(e, 6) ^ sha256_pkg::rotr(e, 11) ^ sha256_pkg::rotr(e, 25))
         + ((e & f) ^ (~e & g)) + sha256_pkg::RoundConsts[rnd_ff] + w0;
      t2 = (sha256_pkg::rotr(a, 2) ^ sha256_pkg::rotr(a, 13) ^ sha256_pkg::rotr(a, 22))
         + ((a & b) ^ (a & c) ^ (b & c));
      s0 = sha256_pkg::rotr(w_ff[479:448], 7) ^ sha256_pkg::rotr(w_ff[479:448], 18)
         ^ (w_ff[479:448] >> 3);
      s1 = sha256_pkg::rotr(w_ff[63:32], 17) ^ sha256_pkg::rotr(w_ff[63:32], 19)
         ^ (w_ff[63:32] >> 10);
      wn = s1 + w_ff[223:192] + s0 + w0;
   end

   assign rsp.valid = state_ff == StOut;
   assign rsp.digest_part = h_ff[255 - 64*part_ff -: 64];
   assign rsp.part_index = part_ff;
   assign rsp.last_part = part_ff == 2'd3;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= StIdle;
         h_ff <= sha256_pkg::InitHash;
         rnd_ff <= '0;
         part_ff <= '0;
         fin_ff <= 1'b0;
      end else begin
         case (state_ff)
            StIdle: if (job_valid) begin
               w_ff <= job.block;
               fin_ff <= job.final_block;
               v_ff <= h_ff;
               rnd_ff <= '0;
               state_ff <= StRound;
            end
            StRound: begin
               v_ff <= {t1 + t2, a, b, c, d + t1, e, f, g};
               w_ff <= {w_ff[479:0], wn};
               rnd_ff <= rnd_ff + 6'd1;
               if (rnd_ff == 6'd63) state_ff <= StAdd;
            end
            StAdd: begin
               for (int i = 0; i < 8; i++)
                  h_ff[255 - 32*i -: 32] <= h_ff[255 - 32*i -: 32] + v_ff[255 - 32*i -: 32];
               part_ff <= '0;
               state_ff <= fin_ff ? StOut : StIdle;
            end
            StOut: if (rsp.ready) begin
               part_ff <= part_ff + 2'd1;
               if (part_ff == 2'd3) begin
                  h_ff <= sha256_pkg::InitHash;
                  state_ff <= StIdle;
               end
            end
            default: state_ff <= StIdle;
         endcase
      end
   end

endmodule
`default_nettype wire

// ----- hdl/sha256_byte_stream_hasher_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// SHA-256 byte stream hasher
// Digest part 0 is offered once the last block (a second padding block if one
// is needed) has passed the queue and the round and add states; the others
// follow one per cycle while rsp.ready is high. Bytes are taken one per cycle
// if the queue has room and no pad block is due; a busy engine takes no block.
// Synchronous reset restores the initial hash and empties all buffers.
// ---------------------------------------------------------------------------
module sha256_byte_stream_hasher_unit #(
   parameter int unsigned QueueDepth = sha256_pkg::QueueDepth
) (
   input wire logic      clock,
   input wire logic      reset,
   sha256_req_if.sink    req,
   sha256_rsp_if.source  rsp
);

   sha256_pkg::job_type f_job, q_job;
   logic f_valid, f_ready, q_valid, q_ready;

   sha256_front u_front (.clock, .reset, .req, .job(f_job), .job_valid(f_valid),
      .job_ready(f_ready));

   sha256_queue #(.Depth(QueueDepth)) u_queue (.clock, .reset, .wr_job(f_job),
      .wr_valid(f_valid), .wr_ready(f_ready), .rd_job(q_job), .rd_valid(q_valid),
      .rd_ready(q_ready));

   sha256_engine u_engine (.clock, .reset, .job(q_job), .job_valid(q_valid),
      .job_ready(q_ready), .rsp);

endmodule
`default_nettype wire
